// File: rtl/lruc_pkg.sv
package lruc_pkg;

  localparam int VALUE_BITS = 64;
  localparam int TIME_BITS  = 32;
  localparam int TTL_BITS   = 16;
  localparam int FUNC_BITS  = 2;
  localparam int KEY_PORT_BITS = 64;

  localparam logic [TTL_BITS-1:0] TTL_RESET = 16'd1000;

  localparam logic [FUNC_BITS-1:0] FUNC_LOOKUP = 2'd0;
  localparam logic [FUNC_BITS-1:0] FUNC_STORE  = 2'd1;
  localparam logic [FUNC_BITS-1:0] FUNC_REMOVE = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_DRAIN  = 5'b00100,
    ST_DECIDE = 5'b01000,
    ST_RESP   = 5'b10000
  } state_t;

endpackage

// File: rtl/lru_cache_with_expiry.sv
// Flow: an accepted request passes the states SCAN, DRAIN and DECIDE to RESP, which offers
//   the result beat once the output is free; only then does the block return to IDLE and
//   take the next request. The tag scan reads one entry of the tag memory per cycle.
// Reset: all entries invalid and all ranks zero at once, ttl_ms back to 1000;
//   no clearing pass, the block is ready as soon as reset is released.
module lru_cache_with_expiry
  import lruc_pkg::*;
#(
  parameter int ENTRIES  = 16,
  parameter int KEY_BITS = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [TTL_BITS-1:0]         cfg_data,   // ttl_ms
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [223:0]                s_tdata,    // key, value_high_in, value_low_in, now_ms
  input  logic [FUNC_BITS-1:0]        s_tuser,    // func
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [2*VALUE_BITS-1:0]     m_tdata,    // value_high_out, value_low_out
  output logic                        m_tuser     // hit
);

  localparam int IW = $clog2(ENTRIES);
  localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);
  localparam int TW = KEY_BITS + TIME_BITS;

  state_t state;

  logic [TTL_BITS-1:0]   ttl_ms;
  logic [FUNC_BITS-1:0]  func_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] vhi_r;
  logic [VALUE_BITS-1:0] vlo_r;
  logic [TIME_BITS-1:0]  now_r;

  logic [IW-1:0] idx;
  logic          cmp_on;
  logic [IW-1:0] cmp_idx;

  logic                 valid [ENTRIES];
  logic [IW-1:0]        rank  [ENTRIES];

  logic [TW-1:0]           tmem [ENTRIES];
  logic [2*VALUE_BITS-1:0] vmem [ENTRIES];
  logic [TW-1:0]           trd;
  logic [2*VALUE_BITS-1:0] vrd;

  logic                 found;
  logic [IW-1:0]        mslot;
  logic [IW-1:0]        mrank;
  logic [TIME_BITS-1:0] mstamp;
  logic                 free_found;
  logic [IW-1:0]        free_slot;
  logic [IW-1:0]        lru_slot;

  logic                 resp_hit;
  logic                 resp_data;

  logic [TIME_BITS-1:0] age;
  logic                 fresh;
  logic                 is_lookup;
  logic                 is_store;
  logic                 is_remove;
  logic                 do_hit;
  logic                 do_inval;
  logic                 do_insert;
  logic [IW-1:0]        ins_slot;
  logic [IW-1:0]        wslot;
  logic                 tag_eq;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);

  always_comb begin
    age       = now_r - mstamp;
    fresh     = age < {{(TIME_BITS-TTL_BITS){1'b0}}, ttl_ms};
    is_lookup = (func_r == FUNC_LOOKUP);
    is_store  = (func_r == FUNC_STORE);
    is_remove = (func_r == FUNC_REMOVE);
    do_hit    = is_lookup && found && fresh;
    do_inval  = found && ((is_lookup && !fresh) || is_remove);
    do_insert = is_store && !found;
    ins_slot  = free_found ? free_slot : lru_slot;
    wslot     = found ? mslot : ins_slot;
    tag_eq    = (trd[KEY_BITS-1:0] == key_r);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ttl_ms <= TTL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      ttl_ms <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      idx      <= '0;
      cmp_on   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      cmp_on <= (state == ST_SCAN);
      if (state == ST_RESP && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          idx <= '0;
          if (s_tvalid) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (idx == LAST) begin
            state <= ST_DRAIN;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ST_DRAIN: begin
          state <= ST_DECIDE;
        end
        ST_DECIDE: begin
          state <= ST_RESP;
        end
        ST_RESP: begin
          if (!m_tvalid || m_tready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_tvalid) begin
      func_r <= s_tuser;
      key_r  <= s_tdata[KEY_BITS-1:0];
      vhi_r  <= s_tdata[127:64];
      vlo_r  <= s_tdata[191:128];
      now_r  <= s_tdata[223:192];
    end
    cmp_idx <= idx;
    if (state == ST_DECIDE) begin
      resp_hit  <= found && (is_store || is_remove || (is_lookup && fresh));
      resp_data <= do_hit;
    end
    if (state == ST_RESP && (!m_tvalid || m_tready)) begin
      m_tuser <= resp_hit;
      m_tdata <= resp_data ? vrd : '0;
    end
  end

  // scan: compare one entry per cycle, in the cycle after its read address
  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      found      <= 1'b0;
      free_found <= 1'b0;
    end else if (cmp_on) begin
      if (valid[cmp_idx] && tag_eq) begin
        found  <= 1'b1;
        mslot  <= cmp_idx;
        mrank  <= rank[cmp_idx];
        mstamp <= trd[TW-1:KEY_BITS];
      end
      if (!valid[cmp_idx] && !free_found) begin
        free_found <= 1'b1;
        free_slot  <= cmp_idx;
      end
      if (valid[cmp_idx] && rank[cmp_idx] == LAST) begin
        lru_slot <= cmp_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    trd <= tmem[idx];
    if (state == ST_DECIDE && do_insert) begin
      tmem[ins_slot] <= {now_r, key_r};
    end
  end

  always_ff @(posedge clk) begin
    vrd <= vmem[mslot];
    if (state == ST_DECIDE && is_store) begin
      vmem[wslot] <= {vlo_r, vhi_r};
    end
  end

  // recency ranks: every entry updates itself against the broadcast slot and rank
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) begin
        valid[i] <= 1'b0;
        rank[i]  <= '0;
      end
    end else if (state == ST_DECIDE) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (do_hit) begin
          if (IW'(i) == mslot) begin
            rank[i] <= '0;
          end else if (valid[i] && rank[i] < mrank) begin
            rank[i] <= rank[i] + 1'b1;
          end
        end else if (do_inval) begin
          if (IW'(i) == mslot) begin
            valid[i] <= 1'b0;
            rank[i]  <= '0;
          end else if (valid[i] && rank[i] > mrank) begin
            rank[i] <= rank[i] - 1'b1;
          end
        end else if (do_insert) begin
          if (IW'(i) == ins_slot) begin
            valid[i] <= 1'b1;
            rank[i]  <= '0;
          end else if (valid[i]) begin
            rank[i] <= rank[i] + 1'b1;
          end
        end
      end
    end
  end

endmodule

// File: dv/lru_cache_with_expiry_test.sv
`timescale 1ns / 100ps
module lru_cache_with_expiry_test;
  import lruc_pkg::*;

  localparam int ENTRIES     = 16;
  localparam int LATENCY     = ENTRIES + 3;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int POOL_SIZE   = 24;
  localparam int PHASE_ITEMS = 200;
  localparam int DUE_DEPTH   = 64;

  localparam logic [FUNC_BITS-1:0] FUNC_UNUSED = 2'd3;

  typedef logic [KEY_PORT_BITS-1:0] key_t;
  typedef logic [VALUE_BITS-1:0]    half_t;
  typedef logic [TIME_BITS-1:0]     ms_t;

  typedef struct packed {
    logic  hit;
    half_t value_high;
    half_t value_low;
  } answer_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [TTL_BITS-1:0]   cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [223:0]          s_tdata = '0;   // key, value_high_in, value_low_in, now_ms
  logic [FUNC_BITS-1:0]  s_tuser = '0;   // func
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [2*VALUE_BITS-1:0] m_tdata;      // value_high_out, value_low_out
  logic                  m_tuser;        // hit

  // shadow copy of the cache
  logic [TTL_BITS-1:0] ttl_ms;
  logic                slot_valid [ENTRIES];
  key_t                slot_tag   [ENTRIES];
  half_t               slot_high  [ENTRIES];
  half_t               slot_low   [ENTRIES];
  ms_t                 slot_stamp [ENTRIES];
  int unsigned         slot_rank  [ENTRIES];

  answer_t due_answers [DUE_DEPTH];
  logic [5:0] due_head = '0;
  logic [5:0] due_tail = '0;
  key_t    key_pool[POOL_SIZE];
  ms_t     clock_ms;
  int      error_count = 0;
  int      cycle_count = 0;
  int      tx_idle_pct = 0;
  int      rx_idle_pct = 0;
  int      rx_hold_req = 0;
  int      rx_left = 0;
  int      rx_gap = 0;

  lru_cache_with_expiry u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic int pick_gap(int pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(60, 20);
    return $urandom_range(3, 1);
  endfunction

  function automatic void cache_clear();
    ttl_ms = TTL_RESET;
    for (int i = 0; i < ENTRIES; i++) begin
      slot_valid[i] = 1'b0;
      slot_tag[i]   = '0;
      slot_high[i]  = '0;
      slot_low[i]   = '0;
      slot_stamp[i] = '0;
      slot_rank[i]  = 0;
    end
  endfunction

  // make slot s most recent; younger slots below lim age by one
  function automatic void make_recent(int s, int unsigned lim);
    for (int i = 0; i < ENTRIES; i++)
      if (i != s && slot_valid[i] && slot_rank[i] < lim) slot_rank[i]++;
    slot_rank[s] = 0;
  endfunction

  function automatic void drop_slot(int s);
    int unsigned r;
    r = slot_rank[s];
    slot_valid[s] = 1'b0;
    slot_rank[s]  = 0;
    for (int i = 0; i < ENTRIES; i++)
      if (slot_valid[i] && slot_rank[i] > r) slot_rank[i]--;
  endfunction

  function automatic answer_t cache_access(logic [FUNC_BITS-1:0] func, key_t key,
                                           half_t vh, half_t vl, ms_t now);
    answer_t     res;
    int          s;
    int unsigned best;
    ms_t         age;
    res = '0;
    s = -1;
    for (int i = 0; i < ENTRIES; i++)
      if (s < 0 && slot_valid[i] && slot_tag[i] == key) s = i;
    case (func)
      FUNC_LOOKUP: begin
        if (s >= 0) begin
          age = now - slot_stamp[s];
          if (age < ttl_ms) begin
            res.hit        = 1'b1;
            res.value_high = slot_high[s];
            res.value_low  = slot_low[s];
            make_recent(s, slot_rank[s]);
          end else begin
            drop_slot(s);
          end
        end
      end
      FUNC_STORE: begin
        if (s >= 0) begin
          res.hit      = 1'b1;
          slot_high[s] = vh;
          slot_low[s]  = vl;
        end else begin
          for (int i = 0; i < ENTRIES; i++)
            if (s < 0 && !slot_valid[i]) s = i;
          if (s < 0) begin
            best = 0;
            s = 0;
            for (int i = 0; i < ENTRIES; i++)
              if (slot_rank[i] > best) begin
                best = slot_rank[i];
                s = i;
              end
            drop_slot(s);
          end
          slot_valid[s] = 1'b1;
          slot_tag[s]   = key;
          slot_high[s]  = vh;
          slot_low[s]   = vl;
          slot_stamp[s] = now;
          make_recent(s, ENTRIES);
        end
      end
      FUNC_REMOVE: begin
        if (s >= 0) begin
          res.hit = 1'b1;
          drop_slot(s);
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic send_req(logic [FUNC_BITS-1:0] func, key_t key, half_t vh, half_t vl,
                          ms_t now);
    int gap;
    gap = pick_gap(tx_idle_pct);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= {now, vl, vh, key};
    do @(posedge clk); while (!s_tready);
    due_answers[due_tail] = cache_access(func, key, vh, vl, now);
    due_tail = due_tail + 6'd1;
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (due_head != due_tail);
  endtask

  task automatic set_ttl(logic [TTL_BITS-1:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    ttl_ms = value;
  endtask

  task automatic send_random_item();
    logic [FUNC_BITS-1:0] func;
    key_t                 key;
    int                   pick;
    pick = $urandom_range(99);
    if (pick < 45)      func = FUNC_LOOKUP;
    else if (pick < 80) func = FUNC_STORE;
    else if (pick < 95) func = FUNC_REMOVE;
    else                func = FUNC_UNUSED;
    if ($urandom_range(9) == 0) key = {$urandom, $urandom};
    else key = key_pool[$urandom_range(POOL_SIZE - 1)];
    if ($urandom_range(49) == 0) clock_ms = $urandom;
    else clock_ms += $urandom_range(int'(ttl_ms) / 6 + 1);
    send_req(func, key, {$urandom, $urandom}, {$urandom, $urandom}, clock_ms);
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %h, actual %h", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin : check_answers
    answer_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (due_head == due_tail) begin
        $error("result beat with nothing outstanding: hit %0b data %h", m_tuser, m_tdata);
        error_count++;
      end else begin
        want = due_answers[due_head];
        due_head = due_head + 6'd1;
        check_field("hit", 64'(want.hit), 64'(m_tuser));
        check_field("value_high_out", want.value_high, m_tdata[63:0]);
        check_field("value_low_out", want.value_low, m_tdata[127:64]);
      end
    end
  end

  always @(posedge clk) begin
    if (rx_hold_req > 0) begin
      rx_left = rx_hold_req;
      rx_hold_req = 0;
    end
    if (rx_left > 0) begin
      m_tready <= 1'b0;
      rx_left--;
    end else if (rx_gap > 0) begin
      m_tready <= 1'b0;
      rx_gap--;
    end else begin
      m_tready <= 1'b1;
      rx_gap = pick_gap(rx_idle_pct);
    end
  end

  task automatic test_directed();
    ms_t t0;
    ms_t t1;
    t0 = 32'hFFFF_FFF0;
    t1 = $urandom;
    send_req(FUNC_LOOKUP, '1, '0, '0, t0);
    send_req(FUNC_STORE, '1, '1, '1, t0);
    send_req(FUNC_LOOKUP, '1, '0, '0, t0 + 999);
    send_req(FUNC_STORE, '1, '0, '0, t0 + 1000);
    send_req(FUNC_LOOKUP, '1, '1, '1, t0 + 1000);
    send_req(FUNC_REMOVE, '1, '0, '0, t0 + 1000);
    send_req(FUNC_STORE, '0, {$urandom, $urandom}, {$urandom, $urandom}, t1);
    send_req(FUNC_REMOVE, '0, '0, '0, t1);
    send_req(FUNC_UNUSED, '0, '1, '1, '1);
    for (int i = 0; i < ENTRIES; i++)
      send_req(FUNC_STORE, key_pool[i], {$urandom, $urandom}, {$urandom, $urandom}, t1 + i);
    send_req(FUNC_LOOKUP, key_pool[0], '0, '0, t1 + 20);
    send_req(FUNC_STORE, key_pool[ENTRIES], {$urandom, $urandom}, {$urandom, $urandom},
             t1 + 21);
    send_req(FUNC_LOOKUP, key_pool[1], '0, '0, t1 + 22);
    send_req(FUNC_LOOKUP, key_pool[0], '0, '0, t1 + 23);
    wait_drained();
  endtask

  task automatic test_ttl_limits();
    key_t fresh;
    ms_t  t;
    fresh = {$urandom, $urandom};
    t = $urandom;
    set_ttl('0);
    send_req(FUNC_STORE, fresh, {$urandom, $urandom}, {$urandom, $urandom}, t);
    send_req(FUNC_LOOKUP, fresh, '0, '0, t);
    send_req(FUNC_STORE, fresh, {$urandom, $urandom}, {$urandom, $urandom}, t);
    set_ttl('1);
    send_req(FUNC_LOOKUP, fresh, '0, '0, t + 65534);
    send_req(FUNC_LOOKUP, fresh, '0, '0, t + 65535);
    set_ttl(TTL_RESET);
  endtask

  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_ttl(16'd5000);
    clock_ms = $urandom;
    rx_hold_req = 400;
    repeat (40) send_random_item();
    wait_drained();
  endtask

  task automatic test_random();
    logic [TTL_BITS-1:0] plan[6];
    plan[0] = TTL_RESET;
    plan[1] = '1;
    plan[2] = '0;
    plan[3] = TTL_BITS'($urandom_range(50, 1));
    plan[4] = TTL_BITS'($urandom_range(65535));
    plan[5] = 16'd1;
    for (int p = 0; p < 6; p++) begin
      tx_idle_pct = (p == 0) ? 0 : $urandom_range(50, 10);
      rx_idle_pct = (p == 0) ? 0 : $urandom_range(50, 10);
      set_ttl(plan[p]);
      clock_ms = $urandom;
      repeat (PHASE_ITEMS) send_random_item();
    end
    wait_drained();
  endtask

  initial begin
    cache_clear();
    key_pool[0] = '1;
    key_pool[1] = '0;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = {$urandom, $urandom};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_ttl_limits();
    test_backpressure();
    test_random();
    repeat (4 * LATENCY) @(posedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: lru_cache_with_expiry.f
rtl/lruc_pkg.sv
rtl/lru_cache_with_expiry.sv
dv/lru_cache_with_expiry_test.sv
